// ===== design/ffra_pkg.sv =====
// shared types and constants for the first-fit region allocator
// no dependencies; used by ffra_cell and first_fit_region_allocator
package ffra_pkg;

    localparam int DEF_MAX_REGIONS  = 32;
    localparam int DEF_EVICT_ROUNDS = 5;
    localparam int POS_W            = 8;

    localparam logic [15:0] TOTAL_RESET = 16'd16384;
    localparam logic [15:0] LFSR_RESET  = 16'h0001;
    localparam logic [15:0] LFSR_TAPS   = 16'hB400;

    localparam logic [2:0] KIND_EVICTED   = 3'd0;
    localparam logic [2:0] KIND_ALLOCATED = 3'd1;
    localparam logic [2:0] KIND_RESIDENT  = 3'd2;
    localparam logic [2:0] KIND_FAILED    = 3'd3;
    localparam logic [2:0] KIND_FREED     = 3'd4;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] start;
        logic [15:0] stop;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [POS_W-1:0]   pos;
    } t_cell_cmd;

endpackage

// ===== design/ffra_cell.sv =====
// one slot of the region table: holds an entry, shifts with its neighbors
// on insert/remove and registers its own id match and gap fit flags
// depends on ffra_pkg
module ffra_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic                i_clk,
    input  ffra_pkg::t_cell_cmd i_cmd,
    input  ffra_pkg::t_entry    i_new,
    input  ffra_pkg::t_entry    i_left,
    input  ffra_pkg::t_entry    i_right,
    input  logic [CW-1:0]       i_count,
    input  logic [7:0]          i_req_id,
    input  logic [15:0]         i_req_size,
    input  logic [15:0]         i_total,
    output ffra_pkg::t_entry    o_entry,
    output logic                o_match,
    output logic                o_fit
);

    localparam logic [ffra_pkg::POS_W-1:0] MY_POS = ffra_pkg::POS_W'(IDX);
    localparam logic [CW:0]                MY_IDX = (CW+1)'(IDX);

    ffra_pkg::t_entry r_entry;
    logic             r_match;
    logic             r_fit;
    logic             w_valid;
    logic             w_last;
    logic [15:0]      w_limit;

    assign w_valid = MY_IDX < {1'b0, i_count};
    assign w_last  = (MY_IDX + (CW+1)'(1)) == {1'b0, i_count};
    // space after this region runs to the next start, or to the top for the last one
    assign w_limit = w_last ? i_total : i_right.start;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ffra_pkg::CELL_INSERT: begin
                if (i_cmd.pos == MY_POS) begin
                    r_entry <= i_new;
                end else if (i_cmd.pos < MY_POS) begin
                    r_entry <= i_left;
                end
            end
            ffra_pkg::CELL_REMOVE: begin
                if (i_cmd.pos <= MY_POS) begin
                    r_entry <= i_right;
                end
            end
            default: begin
            end
        endcase
        r_match <= w_valid && (r_entry.id == i_req_id);
        r_fit   <= w_valid && (w_limit >= r_entry.stop)
                   && ((w_limit - r_entry.stop) >= i_req_size);
    end

    assign o_entry = r_entry;
    assign o_match = r_match;
    assign o_fit   = r_fit;

endmodule

// ===== design/ffra_mod.sv =====
// radix-2 restoring remainder: 16-bit dividend modulo a narrow divisor,
// one quotient bit per cycle; depends on nothing outside this file
// used by first_fit_region_allocator to pick the eviction victim
module ffra_mod #(
    parameter int CW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [15:0]   i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [CW-1:0] o_rem
);

    logic [15:0]   r_dvd;
    logic [CW-1:0] r_div;
    logic [CW-1:0] r_rem;
    logic [4:0]    r_left;
    logic          r_busy;
    logic          r_done;
    logic [CW:0]   w_trial;
    logic [CW:0]   w_sub;

    assign w_trial = {r_rem, r_dvd[15]};
    assign w_sub   = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_left <= 5'd16;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[14:0], 1'b0};
                // remainder stays below the divisor whenever the divisor is nonzero
                r_rem <= (w_trial >= {1'b0, r_div}) ? w_sub[CW-1:0] : w_trial[CW-1:0];
                r_left <= r_left - 5'd1;
                if (r_left == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== design/first_fit_region_allocator.sv =====
// First-fit region allocator. Regions live in a row of MAX_REGIONS cells kept
// sorted by start address; inserts and removals shift the row one slot. A
// request is scanned one cell per cycle, pausing while a table change is
// applied, with accept, settle and output steps around the scan; each table
// change goes through apply and settle, and each eviction waits on the
// remainder unit, then emits the victim and removes it before the table is
// scanned again. Requests are taken one at a time; the final result sits in
// the output register while the next request is accepted. total_memory is
// written through i_cfg_we/i_cfg_data.
// depends on ffra_pkg, ffra_cell, ffra_mod
module first_fit_region_allocator #(
    parameter int MAX_REGIONS  = ffra_pkg::DEF_MAX_REGIONS,
    parameter int EVICT_ROUNDS = ffra_pkg::DEF_EVICT_ROUNDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_owner_id,
    input  logic [15:0] i_request_size,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic [2:0]  o_result_kind,
    output logic [7:0]  o_subject_id,
    output logic [15:0] o_base_address,
    output logic        o_last
);

    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int IW = $clog2(MAX_REGIONS);
    localparam int RW = $clog2(EVICT_ROUNDS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_REGIONS);

    typedef enum logic [3:0] {
        S_IDLE, S_APPLY, S_SETTLE, S_FREE, S_RES, S_FIND, S_FIT, S_MOD, S_EMIT
    } t_state;

    t_state              r_state;
    t_state              r_after;
    ffra_pkg::t_cell_cmd r_cmd;
    ffra_pkg::t_entry    r_new;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_i;
    logic [RW-1:0]       r_round;
    logic [15:0]         r_lfsr;
    logic [15:0]         r_total;
    logic                r_op;
    logic [7:0]          r_id;
    logic [15:0]         r_size;
    logic                r_found;
    logic [15:0]         r_first;
    logic [2:0]          r_pk;
    logic [7:0]          r_pid;
    logic [15:0]         r_pbase;
    logic                r_plast;
    logic                r_evict;
    logic                r_mstart;
    logic                r_ovalid;
    logic [2:0]          r_okind;
    logic [7:0]          r_oid;
    logic [15:0]         r_obase;
    logic                r_olast;

    ffra_pkg::t_entry    w_entry [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] w_match;
    logic [MAX_REGIONS-1:0] w_fit;
    ffra_pkg::t_entry    w_cur;
    logic                w_mdone;
    logic [CW-1:0]       w_mrem;
    logic [15:0]         n_lfsr;
    logic                w_in_range;

    genvar g;
    generate
        for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
            ffra_cell #(.IDX(g), .CW(CW)) u_cell (
                .i_clk      (i_clk),
                .i_cmd      (r_cmd),
                .i_new      (r_new),
                .i_left     ((g == 0) ? w_entry[0] : w_entry[(g == 0) ? 0 : g - 1]),
                .i_right    (w_entry[(g == MAX_REGIONS - 1) ? g : g + 1]),
                .i_count    (r_count),
                .i_req_id   (r_id),
                .i_req_size (r_size),
                .i_total    (r_total),
                .o_entry    (w_entry[g]),
                .o_match    (w_match[g]),
                .o_fit      (w_fit[g])
            );
        end
    endgenerate

    ffra_mod #(.CW(CW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mstart),
        .i_dividend (r_lfsr),
        .i_divisor  (r_count),
        .o_done     (w_mdone),
        .o_rem      (w_mrem)
    );

    assign w_cur      = w_entry[r_i[IW-1:0]];
    assign w_in_range = r_i < r_count;
    assign n_lfsr     = r_lfsr[0] ? ({1'b0, r_lfsr[15:1]} ^ ffra_pkg::LFSR_TAPS)
                                  : {1'b0, r_lfsr[15:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= S_IDLE;
            r_cmd.op <= ffra_pkg::CELL_HOLD;
            r_count  <= '0;
            r_lfsr   <= ffra_pkg::LFSR_RESET;
            r_total  <= ffra_pkg::TOTAL_RESET;
            r_ovalid <= 1'b0;
            r_mstart <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
            if (r_ovalid && i_rsp_ready && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_op    <= i_opcode;
                        r_id    <= i_owner_id;
                        r_size  <= i_request_size;
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_first <= '0;
                        r_round <= '0;
                        r_evict <= 1'b0;
                        r_after <= (i_opcode == ffra_pkg::OP_FREE) ? S_FREE : S_RES;
                        r_state <= S_SETTLE;
                    end
                end
                S_APPLY: begin
                    r_cmd.op <= ffra_pkg::CELL_HOLD;
                    if (r_cmd.op == ffra_pkg::CELL_INSERT) begin
                        r_count <= r_count + CW'(1);
                    end else begin
                        r_count <= r_count - CW'(1);
                    end
                    r_state <= S_SETTLE;
                end
                S_SETTLE: begin
                    // cell flags catch up with the table this cycle
                    r_state <= r_after;
                end
                S_FREE: begin
                    if (w_in_range) begin
                        if (w_match[r_i[IW-1:0]]) begin
                            if (!r_found) begin
                                r_first <= w_cur.start;
                            end
                            r_found   <= 1'b1;
                            r_cmd.op  <= ffra_pkg::CELL_REMOVE;
                            r_cmd.pos <= ffra_pkg::POS_W'(r_i);
                            r_after   <= S_FREE;
                            r_state   <= S_APPLY;
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end else begin
                        r_pk    <= r_found ? ffra_pkg::KIND_FREED : ffra_pkg::KIND_NOT_FOUND;
                        r_pid   <= r_id;
                        r_pbase <= r_first;
                        r_plast <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_RES: begin
                    if (w_in_range) begin
                        if (w_match[r_i[IW-1:0]]) begin
                            r_pk    <= ffra_pkg::KIND_RESIDENT;
                            r_pid   <= r_id;
                            r_pbase <= w_cur.start;
                            r_plast <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end else if (r_size == 16'd0 || r_size > r_total) begin
                        r_pk    <= ffra_pkg::KIND_FAILED;
                        r_pid   <= r_id;
                        r_pbase <= '0;
                        r_plast <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (r_count == '0 || (r_count != FULL && w_entry[0].start >= r_size)) begin
                        r_i         <= '0;
                        r_cmd.op    <= ffra_pkg::CELL_INSERT;
                        r_cmd.pos   <= '0;
                        r_new.id    <= r_id;
                        r_new.start <= '0;
                        r_new.stop  <= r_size;
                        r_pk        <= ffra_pkg::KIND_ALLOCATED;
                        r_pid       <= r_id;
                        r_pbase     <= '0;
                        r_plast     <= 1'b1;
                        r_after     <= S_EMIT;
                        r_state     <= S_APPLY;
                    end else if (r_count == FULL) begin
                        r_state <= S_FIT;
                        r_i     <= r_count;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_FIT;
                    end
                end
                S_FIT: begin
                    if (w_in_range && r_count != FULL) begin
                        if (w_fit[r_i[IW-1:0]]) begin
                            r_cmd.op    <= ffra_pkg::CELL_INSERT;
                            r_cmd.pos   <= ffra_pkg::POS_W'(r_i) + ffra_pkg::POS_W'(1);
                            r_new.id    <= r_id;
                            r_new.start <= w_cur.stop;
                            r_new.stop  <= w_cur.stop + r_size;
                            r_pk        <= ffra_pkg::KIND_ALLOCATED;
                            r_pid       <= r_id;
                            r_pbase     <= w_cur.stop;
                            r_plast     <= 1'b1;
                            r_after     <= S_EMIT;
                            r_state     <= S_APPLY;
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end else if (r_round >= RW'(EVICT_ROUNDS) || r_count == '0) begin
                        r_pk    <= ffra_pkg::KIND_FAILED;
                        r_pid   <= r_id;
                        r_pbase <= '0;
                        r_plast <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_lfsr   <= n_lfsr;
                        r_mstart <= 1'b1;
                        r_state  <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_mstart <= 1'b0;
                    if (w_mdone) begin
                        r_i     <= w_mrem;
                        r_evict <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || i_rsp_ready) begin
                        r_ovalid <= 1'b1;
                        if (r_evict) begin
                            // victim entry is read straight from the row
                            r_okind   <= ffra_pkg::KIND_EVICTED;
                            r_oid     <= w_cur.id;
                            r_obase   <= w_cur.start;
                            r_olast   <= 1'b0;
                            r_evict   <= 1'b0;
                            r_cmd.op  <= ffra_pkg::CELL_REMOVE;
                            r_cmd.pos <= ffra_pkg::POS_W'(r_i);
                            r_round   <= r_round + RW'(1);
                            r_after   <= S_FIND;
                            r_state   <= S_APPLY;
                        end else begin
                            r_okind <= r_pk;
                            r_oid   <= r_pid;
                            r_obase <= r_pbase;
                            r_olast <= r_plast;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready    = (r_state == S_IDLE);
    assign o_rsp_valid    = r_ovalid;
    assign o_result_kind  = r_okind;
    assign o_subject_id   = r_oid;
    assign o_base_address = r_obase;
    assign o_last         = r_olast;

endmodule
